@@ rtl/core/nerg_pkg.sv @@
package nerg_pkg;

  // Default storage depth of one onset set and the nesting bounds.
  localparam int DEF_MAX_SPAN   = 64;
  localparam int MAX_LEVELS     = 4;
  localparam int CARRIED_LEVELS = 4;
  localparam int LEVEL_LIMIT    = (MAX_LEVELS < CARRIED_LEVELS) ? MAX_LEVELS : CARRIED_LEVELS;

  // Field widths of the stream items.
  localparam int SPAN_W  = 7;
  localparam int CNT_W   = 6;
  localparam int ROT_W   = 6;
  localparam int POS_W   = 6;
  localparam int ONSET_W = 6;
  localparam int IVL_W   = 7;
  localparam int LEVEL_W = 3;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 24;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int RIDX_W  = PADDR_W - 2;

  localparam logic [RIDX_W-1:0]  REG_ORDER_MODE    = 1'b0;
  localparam logic [RIDX_W-1:0]  REG_LEVEL_COUNT   = 1'b1;
  localparam logic               ORDER_MODE_RESET  = 1'b0;
  localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 3'd2;
  localparam logic               MODE_SELECT_FIRST = 1'b1;

  typedef struct packed {
    logic               order_mode;
    logic [LEVEL_W-1:0] level_count;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_ERROR,
    S_LEVEL_START,
    S_ROT_WAIT,
    S_STEP_START,
    S_STEP_WAIT,
    S_GEN_IDX,
    S_GEN_ADDR,
    S_GEN_DATA,
    S_LEVEL_END,
    S_EMIT_ADDR,
    S_EMIT_DATA,
    S_EMIT_PUSH,
    S_EMIT_LAST
  } state_t;

endpackage

@@ rtl/core/nested_euclidean_rhythm_gen.sv @@
// Per level: two divisions, then a set sweep writing one onset per cycle on level
// zero, or stepping index, read and write states per onset on deeper levels (registered
// RAM data). Emission: address, data and push states per result; push waits for a free
// output. A bad item gives its single error result. Items are taken one at a time.
// Reset: rst is synchronous; configuration returns to order_mode 0, level_count 2.
module nested_euclidean_rhythm_gen #(
  parameter int  MAX_SPAN = nerg_pkg::DEF_MAX_SPAN,
  localparam int AW       = $clog2(MAX_SPAN),
  localparam int VW       = $clog2(MAX_SPAN)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // span0, span1, span2, span3, span4, rot1, rot2, rot3, rot4, zero pad
  input  logic [nerg_pkg::IN_W-1:0]    s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // position, onset, interval, zero pad
  output logic [nerg_pkg::OUT_W-1:0]   m_tdata,
  output logic                         m_tlast,
  // error
  output logic                         m_tuser,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nerg_pkg::PADDR_W-1:0] paddr,
  input  logic [nerg_pkg::PDATA_W-1:0] pwdata,
  output logic [nerg_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int SPAN_W  = nerg_pkg::SPAN_W;
  localparam int CNT_W   = nerg_pkg::CNT_W;
  localparam int ROT_W   = nerg_pkg::ROT_W;
  localparam int LEVEL_W = nerg_pkg::LEVEL_W;
  localparam int NLEV    = nerg_pkg::CARRIED_LEVELS;
  localparam int RIX_W   = $clog2(NLEV);
  localparam int PAD_W   = nerg_pkg::OUT_W - nerg_pkg::POS_W - nerg_pkg::ONSET_W
                           - nerg_pkg::IVL_W;

  nerg_pkg::cfg_t   cfg;
  nerg_pkg::state_t state, state_next;

  // Item and level registers.
  logic [SPAN_W-1:0]  span_r [0:NLEV];
  logic [ROT_W-1:0]   rot_r  [0:NLEV-1];
  logic [LEVEL_W-1:0] lv_r, lvl, lvl_nx, lv_eff;
  logic [SPAN_W-1:0]  rr_r, q0_r, r0_r, q_r, r_r;
  logic [CNT_W-1:0]   i_r, c_r, idx_r, base_r, kprev_r;
  logic               wrapf_r, cur_r;
  logic [SPAN_W-1:0]  first_r, vprev_r, vcur_r;

  // Output register.
  logic [nerg_pkg::POS_W-1:0]   out_pos, ld_pos;
  logic [nerg_pkg::ONSET_W-1:0] out_onset, ld_onset;
  logic [nerg_pkg::IVL_W-1:0]   out_ivl, ld_ivl;
  logic                         out_last, ld_last, out_err, ld_err;
  logic                         out_load, out_free;

  // Datapath signals.
  logic [SPAN_W-1:0]  n_cur, k_span, rd_val, q_adv, r_adv, r_sum;
  logic [CNT_W-1:0]   k_cur;
  logic [SPAN_W:0]    rot_sum, sel_sum, ivl_sum;
  logic [SPAN_W-1:0]  rot_val, sel_val;
  logic               rot_wrap, sel_wrap, step_carry, last_elem, emit_last, bad;
  logic [CNT_W:0]     rd_sum;
  logic [CNT_W-1:0]   rd_src, rd_idx;
  logic               gen_we, sel_mode;
  logic [VW-1:0]      wval, rdata0, rdata1;

  // Divider interface.
  logic               div_start, div_done;
  logic [SPAN_W-1:0]  div_a, div_b, div_quo, div_rem;

  nerg_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nerg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Two set buffers in ping-pong: cur_r names the one holding the previous level.
  nerg_ram #(.WIDTH(VW), .DEPTH(MAX_SPAN)) u_set0 (
    .clk   (clk),
    .we    (gen_we & cur_r),
    .waddr (AW'(i_r)),
    .wdata (wval),
    .raddr (AW'(rd_idx)),
    .rdata (rdata0)
  );

  nerg_ram #(.WIDTH(VW), .DEPTH(MAX_SPAN)) u_set1 (
    .clk   (clk),
    .we    (gen_we & ~cur_r),
    .waddr (AW'(i_r)),
    .wdata (wval),
    .raddr (AW'(rd_idx)),
    .rdata (rdata1)
  );

  assign sel_mode = (cfg.order_mode == nerg_pkg::MODE_SELECT_FIRST);
  assign lvl_nx   = lvl + LEVEL_W'(1);
  assign n_cur    = span_r[lvl];
  assign k_span   = span_r[lvl_nx];
  assign k_cur    = CNT_W'(k_span);
  assign rd_val   = SPAN_W'(cur_r ? rdata1 : rdata0);
  assign out_free = !m_tvalid || m_tready;

  // Effective level count and span validation.
  always_comb begin
    if (cfg.level_count == '0) begin
      lv_eff = LEVEL_W'(1);
    end else if (cfg.level_count > LEVEL_W'(nerg_pkg::LEVEL_LIMIT)) begin
      lv_eff = LEVEL_W'(nerg_pkg::LEVEL_LIMIT);
    end else begin
      lv_eff = cfg.level_count;
    end
    bad = (span_r[0] == '0) || (span_r[0] > MAX_SPAN);
    for (int j = 1; j <= NLEV; j++) begin
      if ((j <= lv_eff) && ((span_r[j] == '0) || (span_r[j] >= span_r[j-1]))) begin
        bad = 1'b1;
      end
    end
  end

  // Index pattern step: rotated index, value rotation, and the fraction walk.
  always_comb begin
    rot_sum    = {1'b0, q_r} + {1'b0, rr_r};
    rot_wrap   = rot_sum >= {1'b0, n_cur};
    rot_val    = rot_wrap ? SPAN_W'(rot_sum - {1'b0, n_cur}) : SPAN_W'(rot_sum);
    sel_sum    = {1'b0, rd_val} + {1'b0, rr_r};
    sel_wrap   = sel_sum >= {1'b0, span_r[0]};
    sel_val    = sel_wrap ? SPAN_W'(sel_sum - {1'b0, span_r[0]}) : SPAN_W'(sel_sum);
    r_sum      = r_r + r0_r;
    step_carry = r_sum >= k_span;
    r_adv      = step_carry ? (r_sum - k_span) : r_sum;
    q_adv      = q_r + q0_r + SPAN_W'(step_carry);
    last_elem  = (i_r == (k_cur - CNT_W'(1)));
    emit_last  = (i_r == (kprev_r - CNT_W'(1)));
  end

  // Logical-to-physical read address: sets are stored rotated by base_r.
  always_comb begin
    rd_src = (state == nerg_pkg::S_EMIT_ADDR) ? i_r : idx_r;
    rd_sum = {1'b0, rd_src} + {1'b0, base_r};
    rd_idx = (rd_sum >= {1'b0, kprev_r}) ? CNT_W'(rd_sum - {1'b0, kprev_r})
                                         : CNT_W'(rd_sum);
  end

  // Divider operands: rotation reduction first, then span over count.
  always_comb begin
    if (state == nerg_pkg::S_LEVEL_START) begin
      div_a = SPAN_W'(rot_r[lvl[RIX_W-1:0]]);
      div_b = (sel_mode && (lvl != '0)) ? span_r[0] : n_cur;
    end else begin
      div_a = n_cur;
      div_b = k_span;
    end
  end

  assign ivl_sum = {1'b0, span_r[0]} + {1'b0, first_r} - {1'b0, vprev_r};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nerg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    gen_we     = 1'b0;
    wval       = VW'(rd_val);
    out_load   = 1'b0;
    ld_pos     = '0;
    ld_onset   = '0;
    ld_ivl     = '0;
    ld_last    = 1'b0;
    ld_err     = 1'b0;
    unique case (state)
      nerg_pkg::S_IDLE: begin
        if (s_tvalid) state_next = nerg_pkg::S_CHECK;
      end
      nerg_pkg::S_CHECK: begin
        state_next = bad ? nerg_pkg::S_ERROR : nerg_pkg::S_LEVEL_START;
      end
      nerg_pkg::S_ERROR: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_last    = 1'b1;
          ld_err     = 1'b1;
          state_next = nerg_pkg::S_IDLE;
        end
      end
      nerg_pkg::S_LEVEL_START: begin
        div_start  = 1'b1;
        state_next = nerg_pkg::S_ROT_WAIT;
      end
      nerg_pkg::S_ROT_WAIT: begin
        if (div_done) state_next = nerg_pkg::S_STEP_START;
      end
      nerg_pkg::S_STEP_START: begin
        div_start  = 1'b1;
        state_next = nerg_pkg::S_STEP_WAIT;
      end
      nerg_pkg::S_STEP_WAIT: begin
        if (div_done) state_next = nerg_pkg::S_GEN_IDX;
      end
      nerg_pkg::S_GEN_IDX: begin
        if (lvl == '0) begin
          gen_we     = 1'b1;
          wval       = VW'(rot_val);
          state_next = last_elem ? nerg_pkg::S_LEVEL_END : nerg_pkg::S_GEN_IDX;
        end else begin
          state_next = nerg_pkg::S_GEN_ADDR;
        end
      end
      nerg_pkg::S_GEN_ADDR: begin
        state_next = nerg_pkg::S_GEN_DATA;
      end
      nerg_pkg::S_GEN_DATA: begin
        gen_we     = 1'b1;
        wval       = sel_mode ? VW'(sel_val) : VW'(rd_val);
        state_next = last_elem ? nerg_pkg::S_LEVEL_END : nerg_pkg::S_GEN_IDX;
      end
      nerg_pkg::S_LEVEL_END: begin
        state_next = (lvl_nx == lv_r) ? nerg_pkg::S_EMIT_ADDR : nerg_pkg::S_LEVEL_START;
      end
      nerg_pkg::S_EMIT_ADDR: begin
        state_next = nerg_pkg::S_EMIT_DATA;
      end
      nerg_pkg::S_EMIT_DATA: begin
        state_next = nerg_pkg::S_EMIT_PUSH;
      end
      nerg_pkg::S_EMIT_PUSH: begin
        // The result for the previous onset goes out once this onset is known.
        if (i_r == '0) begin
          state_next = emit_last ? nerg_pkg::S_EMIT_LAST : nerg_pkg::S_EMIT_ADDR;
        end else if (out_free) begin
          out_load   = 1'b1;
          ld_pos     = nerg_pkg::POS_W'(i_r - CNT_W'(1));
          ld_onset   = nerg_pkg::ONSET_W'(vprev_r);
          ld_ivl     = nerg_pkg::IVL_W'(vcur_r - vprev_r);
          state_next = emit_last ? nerg_pkg::S_EMIT_LAST : nerg_pkg::S_EMIT_ADDR;
        end
      end
      nerg_pkg::S_EMIT_LAST: begin
        // The last interval wraps through the outer span.
        if (out_free) begin
          out_load   = 1'b1;
          ld_pos     = nerg_pkg::POS_W'(kprev_r - CNT_W'(1));
          ld_onset   = nerg_pkg::ONSET_W'(vprev_r);
          ld_ivl     = nerg_pkg::IVL_W'(ivl_sum);
          ld_last    = 1'b1;
          state_next = nerg_pkg::S_IDLE;
        end
      end
      default: state_next = nerg_pkg::S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      nerg_pkg::S_IDLE: begin
        if (s_tvalid) begin
          span_r[0] <= s_tdata[SPAN_W-1:0];
          for (int j = 1; j <= NLEV; j++) begin
            span_r[j] <= SPAN_W'(s_tdata[SPAN_W + (j-1)*CNT_W +: CNT_W]);
            rot_r[j-1] <= s_tdata[SPAN_W + NLEV*CNT_W + (j-1)*ROT_W +: ROT_W];
          end
        end
      end
      nerg_pkg::S_CHECK: begin
        lv_r  <= lv_eff;
        lvl   <= '0;
        cur_r <= 1'b0;
      end
      nerg_pkg::S_ROT_WAIT: begin
        if (div_done) rr_r <= div_rem;
      end
      nerg_pkg::S_STEP_WAIT: begin
        if (div_done) begin
          q0_r <= div_quo;
          r0_r <= div_rem;
          q_r  <= '0;
          r_r  <= '0;
          i_r  <= '0;
          c_r  <= '0;
        end
      end
      nerg_pkg::S_GEN_IDX: begin
        if (lvl == '0) begin
          q_r <= q_adv;
          r_r <= r_adv;
          i_r <= i_r + CNT_W'(1);
          c_r <= c_r + CNT_W'(rot_wrap);
        end else begin
          idx_r   <= sel_mode ? CNT_W'(q_r) : CNT_W'(rot_val);
          wrapf_r <= !sel_mode && rot_wrap;
        end
      end
      nerg_pkg::S_GEN_DATA: begin
        q_r <= q_adv;
        r_r <= r_adv;
        i_r <= i_r + CNT_W'(1);
        c_r <= c_r + CNT_W'(sel_mode ? sel_wrap : wrapf_r);
      end
      nerg_pkg::S_LEVEL_END: begin
        // Wrapped entries sit at the tail; the sorted set starts at the first of them.
        base_r  <= (c_r == '0) ? '0 : (k_cur - c_r);
        kprev_r <= k_cur;
        cur_r   <= ~cur_r;
        lvl     <= lvl_nx;
        i_r     <= '0;
      end
      nerg_pkg::S_EMIT_DATA: begin
        vcur_r <= rd_val;
        if (i_r == '0) first_r <= rd_val;
      end
      nerg_pkg::S_EMIT_PUSH: begin
        if ((i_r == '0) || out_free) begin
          vprev_r <= vcur_r;
          if (!emit_last) i_r <= i_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register: holds a finished result until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos   <= ld_pos;
      out_onset <= ld_onset;
      out_ivl   <= ld_ivl;
      out_last  <= ld_last;
      out_err   <= ld_err;
    end
  end

  assign s_tready = (state == nerg_pkg::S_IDLE);
  assign m_tdata  = {{PAD_W{1'b0}}, out_ivl, out_onset, out_pos};
  assign m_tlast  = out_last;
  assign m_tuser  = out_err;

  // An error result is always the last one of its item.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("error result without last flag");

  // Physical read addresses stay inside the previous set.
  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == nerg_pkg::S_GEN_ADDR || state == nerg_pkg::S_EMIT_ADDR) |-> rd_idx < kprev_r)
    else $error("set read address beyond set size");

  // The wrap count never exceeds the number of entries written.
  a_wrap_count: assert property (@(posedge clk) disable iff (rst)
    (state == nerg_pkg::S_LEVEL_END) |-> c_r <= k_cur)
    else $error("wrap count above set size");

  // Divider results arrive only while the sequencer waits for them.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == nerg_pkg::S_ROT_WAIT || state == nerg_pkg::S_STEP_WAIT))
    else $error("divider finished outside a wait state");

endmodule

@@ rtl/core/nerg_ram.sv @@
module nerg_ram #(
  parameter int  WIDTH = nerg_pkg::CNT_W,
  parameter int  DEPTH = nerg_pkg::DEF_MAX_SPAN,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/nerg_div.sv @@
module nerg_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nerg_pkg::SPAN_W-1:0] dividend,
  input  logic [nerg_pkg::SPAN_W-1:0] divisor,
  output logic                        done,
  output logic [nerg_pkg::SPAN_W-1:0] quotient,
  output logic [nerg_pkg::SPAN_W-1:0] remainder
);

  localparam int W     = nerg_pkg::SPAN_W;
  localparam int CNT_W = $clog2(W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [W:0]       rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [W:0]       shifted;
  logic             fits;

  // One quotient bit per cycle, restoring form.
  assign shifted = {rem[W-1:0], quo[W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem[W-1:0];

endmodule

@@ rtl/core/nerg_cfg.sv @@
module nerg_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nerg_pkg::PADDR_W-1:0] paddr,
  input  logic [nerg_pkg::PDATA_W-1:0] pwdata,
  output logic [nerg_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output nerg_pkg::cfg_t               cfg
);

  logic                          wr;
  logic [nerg_pkg::RIDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[nerg_pkg::PADDR_W-1:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.order_mode  <= nerg_pkg::ORDER_MODE_RESET;
      cfg.level_count <= nerg_pkg::LEVEL_COUNT_RESET;
    end else if (wr) begin
      unique case (idx)
        nerg_pkg::REG_ORDER_MODE:  cfg.order_mode  <= pwdata[0];
        nerg_pkg::REG_LEVEL_COUNT: cfg.level_count <= pwdata[nerg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (idx)
      nerg_pkg::REG_ORDER_MODE:  prdata = nerg_pkg::PDATA_W'(cfg.order_mode);
      nerg_pkg::REG_LEVEL_COUNT: prdata = nerg_pkg::PDATA_W'(cfg.level_count);
      default:                   prdata = '0;
    endcase
  end

endmodule

@@ tb/tb.sv @@
module tb;
  import nerg_pkg::*;

  localparam int SET_DEPTH   = DEF_MAX_SPAN;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASES      = 9;
  localparam int PER_PHASE   = 27;

  // Expected fields of one emitted onset.
  typedef struct {
    bit [POS_W-1:0]   position;
    bit [ONSET_W-1:0] onset;
    bit [IVL_W-1:0]   interval;
    bit               last;
    bit               error;
  } onset_rec_t;

  // Kinds of generated input items.
  typedef enum int {ITEM_LEGAL, ITEM_WIDEST, ITEM_NARROWEST, ITEM_NOISE} item_kind_t;

  // Rhythm predictor and result checker with its own copy of the registers.
  class onset_scoreboard;
    bit               order_mode  = ORDER_MODE_RESET;
    bit [LEVEL_W-1:0] level_count = LEVEL_COUNT_RESET;
    onset_rec_t       expected_onsets[$];
    int               fail_count;
    int               prev[SET_DEPTH];
    int               work[SET_DEPTH];
    int               nxt[SET_DEPTH];

    // Number of nesting levels that the current register value selects.
    function int levels_in_use();
      if (level_count == 0) return 1;
      if (level_count > LEVEL_LIMIT) return LEVEL_LIMIT;
      return level_count;
    endfunction

    // Insertion sort of the first n entries of the work set.
    function void sort_work(int n);
      int v, j;
      for (int i = 1; i < n; i++) begin
        v = work[i];
        j = i;
        while (j > 0 && work[j-1] > v) begin
          work[j] = work[j-1];
          j--;
        end
        work[j] = v;
      end
    endfunction

    // Evenly spread k points over n, shifted by r, sorted into the work set.
    function void fill_pattern(int n, int k, int r);
      for (int i = 0; i < k; i++) work[i] = ((i * n) / k + r % n) % n;
      sort_work(k);
    endfunction

    // Work out the onsets that one accepted item must produce.
    function void note_item(logic [IN_W-1:0] d);
      int sp[5];
      int rt[5];
      int lv, k, iv;
      bit bad;
      onset_rec_t rec;
      sp[0] = d[6:0];
      rt[0] = 0;
      for (int j = 1; j <= 4; j++) begin
        sp[j] = d[7 + CNT_W*(j-1) +: CNT_W];
        rt[j] = d[31 + ROT_W*(j-1) +: ROT_W];
      end
      lv = levels_in_use();
      bad = (sp[0] == 0 || sp[0] > SET_DEPTH);
      for (int j = 1; j <= lv; j++)
        if (sp[j] == 0 || sp[j] >= sp[j-1]) bad = 1;
      if (bad) begin
        rec = '{position: 0, onset: 0, interval: 0, last: 1, error: 1};
        expected_onsets.push_back(rec);
        return;
      end
      // Level zero, then each deeper level picks from the previous set.
      fill_pattern(sp[0], sp[1], rt[1]);
      prev = work;
      for (int j = 1; j < lv; j++) begin
        fill_pattern(sp[j], sp[j+1], order_mode ? 0 : rt[j+1]);
        for (int i = 0; i < sp[j+1]; i++) nxt[i] = prev[work[i]];
        if (order_mode == MODE_SELECT_FIRST) begin
          for (int i = 0; i < sp[j+1]; i++) work[i] = (nxt[i] + rt[j+1] % sp[0]) % sp[0];
          sort_work(sp[j+1]);
          prev = work;
        end else begin
          prev = nxt;
        end
      end
      // Emission with intervals; the last one wraps through the outer span.
      k = sp[lv];
      for (int i = 0; i < k; i++) begin
        iv = (i + 1 < k) ? prev[i+1] - prev[i] : sp[0] + prev[0] - prev[k-1];
        rec = '{position: i, onset: prev[i], interval: iv, last: (i + 1 == k), error: 0};
        expected_onsets.push_back(rec);
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_onset(logic [OUT_W-1:0] d, logic lst, logic err);
      onset_rec_t want;
      if (expected_onsets.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected onset: tdata %h last %b error %b", d, lst, err);
        return;
      end
      want = expected_onsets.pop_front();
      if (d[5:0] !== want.position || d[11:6] !== want.onset ||
          d[18:12] !== want.interval || lst !== want.last || err !== want.error) begin
        fail_count++;
        if (fail_count <= 10)
          $display("onset mismatch: expected pos %0d onset %0d ivl %0d last %b err %b, got pos %0d onset %0d ivl %0d last %b err %b",
                   want.position, want.onset, want.interval, want.last, want.error,
                   d[5:0], d[11:6], d[18:12], lst, err);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // span0, span1, span2, span3, span4, rot1, rot2, rot3, rot4, zero pad
  logic [IN_W-1:0]    s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // position, onset, interval, zero pad
  logic [OUT_W-1:0]   m_tdata;
  logic               m_tlast;
  // error
  logic               m_tuser;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  onset_scoreboard sb = new();
  int send_idle_pct = 30;
  int recv_idle_pct = 71;
  int stall_cycles  = 0;
  int random_sent   = 0;

  nested_euclidean_rhythm_gen i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Output side: random back-pressure and checking of every accepted onset.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_onset(m_tdata, m_tlast, m_tuser);
    m_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Pack spans and rotations into the input word.
  function automatic logic [IN_W-1:0] pack_item(int sp[5], int rt[5]);
    logic [IN_W-1:0] d;
    d = '0;
    d[6:0] = sp[0];
    for (int j = 1; j <= 4; j++) begin
      d[7 + CNT_W*(j-1) +: CNT_W]  = sp[j];
      d[31 + ROT_W*(j-1) +: ROT_W] = rt[j];
    end
    return d;
  endfunction

  // Build one item for lv levels: legal chains, extremes or raw noise.
  function automatic logic [IN_W-1:0] make_item(int lv, item_kind_t kind);
    int sp[5];
    int rt[5];
    logic [IN_W-1:0] d;
    if (kind == ITEM_NOISE) begin
      d = {$urandom, $urandom};
      d[IN_W-1] = 1'b0;
      return d;
    end
    for (int j = 0; j <= 4; j++) begin
      sp[j] = $urandom_range(63);
      rt[j] = (kind == ITEM_WIDEST) ? 63 : $urandom_range(63);
    end
    case (kind)
      ITEM_WIDEST: begin
        for (int j = 0; j <= lv; j++) sp[j] = SET_DEPTH - j;
      end
      ITEM_NARROWEST: begin
        for (int j = 0; j <= lv; j++) sp[j] = lv + 1 - j;
      end
      default: begin
        // Mostly short cycles, sometimes the full outer span.
        sp[0] = $urandom_range(lv + 1, ($urandom_range(3) == 0) ? SET_DEPTH : 20);
        for (int j = 1; j <= lv; j++) sp[j] = $urandom_range(lv - j + 1, sp[j-1] - 1);
      end
    endcase
    return pack_item(sp, rt);
  endfunction

  // Offer one item, with random gaps before it, and record it on acceptance.
  task automatic send_item(logic [IN_W-1:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(d);
  endtask

  // Hold the sender until every expected onset has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.expected_onsets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(logic [RIDX_W-1:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ORDER_MODE) sb.order_mode = value[0];
    else sb.level_count = value[LEVEL_W-1:0];
  endtask

  // Directed items under reset settings: span0..span4, rot1..rot4.
  int directed_items[16][9] = '{
    '{64, 63, 62,  0,  0, 63, 63,  0,  0},
    '{ 3,  2,  1,  0,  0,  0,  0,  0,  0},
    '{ 2,  1,  0,  0,  0,  1,  0,  0,  0},
    '{ 0,  5,  3,  0,  0,  0,  0,  0,  0},
    '{65, 63, 62,  0,  0,  0,  0,  0,  0},
    '{127, 63, 63, 63, 63, 63, 63, 63, 63},
    '{10, 10,  5,  0,  0,  0,  0,  0,  0},
    '{10,  5,  5,  0,  0,  0,  0,  0,  0},
    '{10,  0,  0,  0,  0,  0,  0,  0,  0},
    '{16,  8,  4, 63, 63,  3,  1, 63, 63},
    '{16,  5,  3,  0,  0, 63, 63,  0,  0},
    '{64, 32, 16,  0,  0, 33, 17,  0,  0},
    '{12,  7,  4,  0,  0,  5,  2,  0,  0},
    '{ 8,  3,  2,  0,  0,  0, 40,  0,  0},
    '{64,  2,  1,  0,  0, 63,  1,  0,  0},
    '{ 7,  6,  5,  0,  0,  6,  5,  0,  0}
  };

  // Register settings of the random phases: order mode, level count.
  int phase_cfg[PHASES][2] = '{
    '{0, 1}, '{1, 2}, '{0, 4}, '{1, 4}, '{1, 3}, '{0, 0}, '{1, 7}, '{0, 3}, '{1, 5}
  };

  initial begin
    int sp[5];
    int rt[5];
    int lv;
    item_kind_t kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset register values.
    for (int n = 0; n < 16; n++) begin
      for (int j = 0; j <= 4; j++) sp[j] = directed_items[n][j];
      rt[0] = 0;
      for (int j = 1; j <= 4; j++) rt[j] = directed_items[n][4 + j];
      send_item(pack_item(sp, rt));
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      reg_write(REG_ORDER_MODE, phase_cfg[p][0]);
      reg_write(REG_LEVEL_COUNT, phase_cfg[p][1]);
      lv = sb.levels_in_use();
      for (int n = 0; n < PER_PHASE; n++) begin
        if (random_sent < 80) begin
          send_idle_pct = 30;
          recv_idle_pct = 71;
        end else if (random_sent < 160) begin
          send_idle_pct = 71;
          recv_idle_pct = 30;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == 0) kind = ITEM_WIDEST;
        else if (n == 1) kind = ITEM_NARROWEST;
        else if ($urandom_range(99) < 15) kind = ITEM_NOISE;
        else kind = ITEM_LEGAL;
        send_item(make_item(lv, kind));
        random_sent++;
      end
    end

    // Let the last onsets drain, then give the verdict.
    wait_drained();
    repeat (50) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_onsets.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
